/* design/tspp_pkg.sv */
// ---------------------------------------------------------------------------
// tspp_pkg
// Shared types, codes and helpers for the two-slot pattern prefetch control.
// ---------------------------------------------------------------------------
package tspp_pkg;

  localparam logic [7:0] EMPTY_PAT = 8'hFF;

  localparam logic [1:0] MODE_ADVANCE = 2'd0;
  localparam logic [1:0] MODE_LOAD    = 2'd1;
  localparam logic [1:0] MODE_LOOKUP  = 2'd2;

  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_NOT_RESIDENT = 2'd1;
  localparam logic [1:0] STAT_NOT_LOADED  = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] current_pattern;
    logic [7:0] next_pattern;
    logic [7:0] query_pattern;
    logic [5:0] row;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] row_address;
    logic        load_issued;
    logic        load_seek;
    logic [31:0] file_offset;
    logic [10:0] buffer_address;
    logic        section_done;
    logic        need_prefetch;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } tspp_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Some assigned slot still has a section that is not loaded
  function automatic logic calc_need(logic [7:0] pat_a, logic [7:0] pat_b,
                                     logic [7:0] valid);
    logic a_inc;
    logic b_inc;
    a_inc = (pat_a != EMPTY_PAT) && (valid[3:0] != 4'hF);
    b_inc = (pat_b != EMPTY_PAT) && (valid[7:4] != 4'hF);
    return a_inc | b_inc;
  endfunction

endpackage

/* design/tspp_ctrl.sv */
// ---------------------------------------------------------------------------
// tspp_ctrl
// Transaction sequencer: capture, execute, and hold the result register.
// ---------------------------------------------------------------------------
module tspp_ctrl
  import tspp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output tspp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd.capture   = 1'b0;
    cmd.commit    = 1'b0;
    in_stall      = 1'b1;
    // drop the result once the sink takes it
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // commit only when the result register is free this cycle
        if (!out_valid_r || !out_stall) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* design/tspp_datapath.sv */
// ---------------------------------------------------------------------------
// tspp_datapath
// Slot state, chunk position, offset register and result computation.
// ---------------------------------------------------------------------------
module tspp_datapath
  import tspp_pkg::*;
#(
  parameter int CHANNELS    = 4,
  parameter int CHUNK_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  tspp_cmd_t   cmd,
  input  in_item_t    in_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic [31:0] cfg_offset,
  output out_item_t   out_data
);

  localparam int ROW_BYTES     = 4 * CHANNELS;
  localparam int SECTION_BYTES = 16 * ROW_BYTES;
  localparam int SLOT_BYTES    = 4 * SECTION_BYTES;
  localparam int SUBS_RAW      = SECTION_BYTES / CHUNK_BYTES;
  localparam int SUBS          = (SUBS_RAW > 0) ? SUBS_RAW : 1;
  localparam int CW            = (SUBS > 1) ? $clog2(SUBS) : 1;

  localparam logic [CW-1:0] CHUNK_LAST = CW'(SUBS - 1);
  localparam logic [10:0]   ROW_B11    = 11'(ROW_BYTES);
  localparam logic [10:0]   SECT_B11   = 11'(SECTION_BYTES);
  localparam logic [10:0]   PAT_B11    = 11'(SLOT_BYTES);
  localparam logic [10:0]   CHUNK_B11  = 11'(CHUNK_BYTES);
  localparam logic [31:0]   SECT_B32   = 32'(SECTION_BYTES);
  localparam logic [31:0]   PAT_B32    = 32'(SLOT_BYTES);

  in_item_t        in_r;
  logic [31:0]     offset_r;
  logic [7:0]      slot_a_r,   slot_a_nxt;
  logic [7:0]      slot_b_r,   slot_b_nxt;
  logic [7:0]      valid_r,    valid_nxt;
  logic [7:0]      want_cur_r, want_cur_nxt;
  logic [7:0]      want_nxt_r, want_nxt_nxt;
  logic [CW-1:0]   chunk_r,    chunk_nxt;
  logic            prefetch_r, prefetch_nxt;
  out_item_t       out_r,      out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= '0;
      slot_a_r   <= EMPTY_PAT;
      slot_b_r   <= EMPTY_PAT;
      valid_r    <= '0;
      want_cur_r <= EMPTY_PAT;
      want_nxt_r <= EMPTY_PAT;
      chunk_r    <= '0;
      prefetch_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        offset_r <= cfg_wdata;
      end
      if (cmd.commit) begin
        slot_a_r   <= slot_a_nxt;
        slot_b_r   <= slot_b_nxt;
        valid_r    <= valid_nxt;
        want_cur_r <= want_cur_nxt;
        want_nxt_r <= want_nxt_nxt;
        chunk_r    <= chunk_nxt;
        prefetch_r <= prefetch_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  always_comb begin
    logic        have_cur, have_nxt, keep_a, keep_b;
    logic        a_inc, b_inc, found, pick_b, last;
    logic [7:0]  pat;
    logic [3:0]  bits;
    logic [1:0]  sect;
    logic [7:0]  req;
    logic        hit_a, hit_b;
    logic [10:0] base;

    slot_a_nxt   = slot_a_r;
    slot_b_nxt   = slot_b_r;
    valid_nxt    = valid_r;
    want_cur_nxt = want_cur_r;
    want_nxt_nxt = want_nxt_r;
    chunk_nxt    = chunk_r;
    prefetch_nxt = prefetch_r;
    out_nxt      = '0;

    have_cur = 1'b0;
    have_nxt = 1'b0;
    keep_a   = 1'b0;
    keep_b   = 1'b0;
    a_inc    = valid_r[3:0] != 4'hF;
    b_inc    = valid_r[7:4] != 4'hF;
    found    = 1'b0;
    pick_b   = 1'b0;
    last     = chunk_r == CHUNK_LAST;
    pat      = EMPTY_PAT;
    bits     = '0;
    sect     = '0;
    req      = '0;
    hit_a    = in_r.query_pattern == slot_a_r;
    hit_b    = in_r.query_pattern == slot_b_r;
    base     = '0;

    case (in_r.mode)
      MODE_ADVANCE: begin
        want_cur_nxt = in_r.current_pattern;
        want_nxt_nxt = in_r.next_pattern;
        chunk_nxt    = '0;
        if (in_r.current_pattern == slot_a_r) begin
          have_cur = 1'b1;
          keep_a   = 1'b1;
        end else if (in_r.current_pattern == slot_b_r) begin
          have_cur = 1'b1;
          keep_b   = 1'b1;
        end
        if (in_r.next_pattern == slot_a_r) begin
          have_nxt = 1'b1;
          keep_a   = 1'b1;
        end else if (in_r.next_pattern == slot_b_r) begin
          have_nxt = 1'b1;
          keep_b   = 1'b1;
        end
        // free a slot that holds neither pattern and hand it to a missing one
        if (!keep_a) begin
          slot_a_nxt     = EMPTY_PAT;
          valid_nxt[3:0] = 4'h0;
          if (!have_cur) begin
            slot_a_nxt = in_r.current_pattern;
            have_cur   = 1'b1;
          end else if (!have_nxt) begin
            slot_a_nxt = in_r.next_pattern;
            have_nxt   = 1'b1;
          end
        end
        if (!keep_b) begin
          slot_b_nxt     = EMPTY_PAT;
          valid_nxt[7:4] = 4'h0;
          if (!have_cur) begin
            slot_b_nxt = in_r.current_pattern;
          end else if (!have_nxt) begin
            slot_b_nxt = in_r.next_pattern;
          end
        end
        prefetch_nxt = calc_need(slot_a_nxt, slot_b_nxt, valid_nxt);
      end
      MODE_LOAD: begin
        if (want_cur_r == slot_a_r && a_inc) begin
          found = 1'b1;
        end else if (want_cur_r == slot_b_r && b_inc) begin
          found  = 1'b1;
          pick_b = 1'b1;
        end else if (want_nxt_r == slot_a_r && a_inc) begin
          found = 1'b1;
        end else if (want_nxt_r == slot_b_r && b_inc) begin
          found  = 1'b1;
          pick_b = 1'b1;
        end
        if (found) begin
          pat = pick_b ? slot_b_r : slot_a_r;
        end
        if (pat == EMPTY_PAT) begin
          prefetch_nxt = 1'b0;
          chunk_nxt    = '0;
        end else begin
          bits = pick_b ? valid_r[7:4] : valid_r[3:0];
          if (!bits[0]) begin
            sect = 2'd0;
          end else if (!bits[1]) begin
            sect = 2'd1;
          end else if (!bits[2]) begin
            sect = 2'd2;
          end else begin
            sect = 2'd3;
          end
          out_nxt.load_issued    = 1'b1;
          out_nxt.load_seek      = chunk_r == '0;
          out_nxt.file_offset    = offset_r + 32'(pat) * PAT_B32 + 32'(sect) * SECT_B32;
          out_nxt.buffer_address = (pick_b ? PAT_B11 : 11'd0) + 11'(sect) * SECT_B11
                                 + 11'(chunk_r) * CHUNK_B11;
          if (last) begin
            // section complete: mark it and recheck the need flag
            chunk_nxt                      = '0;
            valid_nxt[{pick_b, sect}]      = 1'b1;
            out_nxt.section_done           = 1'b1;
            prefetch_nxt = calc_need(slot_a_r, slot_b_r, valid_nxt);
          end else begin
            chunk_nxt = chunk_r + CW'(1);
          end
        end
      end
      MODE_LOOKUP: begin
        if (hit_a || hit_b) begin
          req = hit_a ? {4'h0, valid_r[3:0]} : {4'h0, valid_r[7:4]};
          base = hit_a ? 11'd0 : PAT_B11;
          if (!req[in_r.row[5:4]]) begin
            out_nxt.status = STAT_NOT_LOADED;
          end else begin
            out_nxt.status      = STAT_OK;
            out_nxt.row_address = base + 11'(in_r.row) * ROW_B11;
          end
        end else begin
          out_nxt.status = STAT_NOT_RESIDENT;
        end
      end
      default: begin
        // unknown mode: state holds
      end
    endcase

    out_nxt.need_prefetch = prefetch_nxt;
  end

  assign cfg_offset = offset_r;
  assign out_data   = out_r;

endmodule

/* design/two_slot_pattern_prefetch_control.sv */
// Flow: a transaction is captured in idle, then executed; out_valid rises
// when execute commits the result to the result register.
// The sequencer takes one transaction at a time and waits in execute
// while the result register is still occupied.
// Reset (synchronous, rst_n low): both slots empty (pattern 255), all
// section valid bits clear, wanted patterns 255, chunk position and need flag 0.
// ---------------------------------------------------------------------------
// two_slot_pattern_prefetch_control
// Two pattern buffer slots, four sections each: advance reassigns slots,
// load step issues at most one chunk read, row lookup locates a resident row.
// ---------------------------------------------------------------------------
module two_slot_pattern_prefetch_control
  import tspp_pkg::*;
#(
  parameter int CHANNELS    = 4,
  parameter int CHUNK_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  tspp_cmd_t   cmd;
  logic        cfg_hit;
  logic        cfg_we;
  logic [31:0] cfg_offset;

  // Only word 0 (pattern data offset) exists; word 1 reads as zero and
  // ignores writes.
  assign cfg_pready = 1'b1;
  assign cfg_hit    = !cfg_paddr[2];
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? cfg_offset : 32'd0;

  // Sequencer: accepts a transaction in idle, commits it once the result
  // register can take the new result.
  tspp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Slot bookkeeping and address arithmetic; slot state advances on commit only.
  tspp_datapath #(
    .CHANNELS    (CHANNELS),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_pwdata),
    .cfg_offset (cfg_offset),
    .out_data   (out_data)
  );

endmodule
